@@ src/stia_pkg.sv @@
package stia_pkg;

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_FIND   = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;
  localparam logic [1:0] REQ_QUERY  = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  // fixed port field widths
  localparam int REQ_W   = 2;
  localparam int KEY_W   = 16;
  localparam int STAT_W  = 2;
  localparam int SLOT_W  = 4;
  localparam int NEWID_W = 16;

endpackage

@@ src/slot_table_id_allocator_core.sv @@
// Slot table with running identifier allocation; one slot is scanned per cycle.
// Query, insert on a full table and find/delete on an empty table go from idle
// straight to the done state; other requests scan the RAM from slot 0 up to the
// first hit or the last slot. The result is then registered at the output.
// Throughput: one request at a time; the next one is accepted once the result is queued.
// Reset: synchronous, active low; a clearing pass over all SLOT_COUNT slots follows.
module slot_table_id_allocator_core #(
  parameter int SLOT_COUNT = 16,
  parameter int ID_BITS    = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [stia_pkg::REQ_W-1:0]   in_req_type,
  input  logic [stia_pkg::KEY_W-1:0]   in_key_id,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [stia_pkg::STAT_W-1:0]  out_status,
  output logic [stia_pkg::SLOT_W-1:0]  out_slot_index,
  output logic [stia_pkg::NEWID_W-1:0] out_new_id,
  output logic                         out_any_occupied
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int ENT_W = ID_BITS + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOT_COUNT);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] scan_addr_r, scan_addr_nxt;
  logic issue_end_r, issue_end_nxt;
  logic rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [stia_pkg::REQ_W-1:0] req_r, req_nxt;
  logic [ID_BITS-1:0] key_r, key_nxt;
  logic [CNT_W-1:0] occ_cnt_r, occ_cnt_nxt;
  logic [ID_BITS-1:0] id_ctr_r, id_ctr_nxt;
  logic [stia_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic [IDX_W-1:0] res_idx_r, res_idx_nxt;
  logic [ID_BITS-1:0] res_id_r, res_id_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [stia_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [stia_pkg::SLOT_W-1:0] out_idx_r, out_idx_nxt;
  logic [stia_pkg::NEWID_W-1:0] out_id_r, out_id_nxt;
  logic out_occ_r, out_occ_nxt;

  logic wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic [ENT_W-1:0] rd_data;
  logic slot_hit;

  stia_slot_ram #(
    .DEPTH(SLOT_COUNT),
    .WIDTH(ENT_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(scan_addr_r),
    .rd_data(rd_data)
  );

  // insert looks for a free slot, find/delete for a valid slot with matching id
  assign slot_hit = (req_r == stia_pkg::REQ_INSERT) ? !rd_data[ID_BITS] :
                    (rd_data[ID_BITS] && (rd_data[ID_BITS-1:0] == key_r));

  always_comb begin
    state_nxt      = state_r;
    scan_addr_nxt  = scan_addr_r;
    issue_end_nxt  = issue_end_r;
    rd_vld_nxt     = rd_vld_r;
    rd_idx_nxt     = rd_idx_r;
    req_nxt        = req_r;
    key_nxt        = key_r;
    occ_cnt_nxt    = occ_cnt_r;
    id_ctr_nxt     = id_ctr_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_id_nxt     = res_id_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_id_nxt     = out_id_r;
    out_occ_nxt    = out_occ_r;
    wr_en          = 1'b0;
    wr_addr        = rd_idx_r;
    wr_data        = '0;

    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = scan_addr_r;
        if (scan_addr_r == LAST_IDX) begin
          scan_addr_nxt = '0;
          state_nxt     = ST_IDLE;
        end else begin
          scan_addr_nxt = scan_addr_r + IDX_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt        = in_req_type;
          key_nxt        = ID_BITS'(in_key_id);
          res_status_nxt = stia_pkg::STAT_OK;
          res_idx_nxt    = '0;
          res_id_nxt     = '0;
          scan_addr_nxt  = '0;
          issue_end_nxt  = 1'b0;
          rd_vld_nxt     = 1'b0;
          state_nxt      = ST_SCAN;
          unique case (in_req_type) inside
            stia_pkg::REQ_INSERT: begin
              if (occ_cnt_r == FULL_CNT) begin
                res_status_nxt = stia_pkg::STAT_FULL;
                state_nxt      = ST_DONE;
              end
            end
            stia_pkg::REQ_FIND, stia_pkg::REQ_DELETE: begin
              if (occ_cnt_r == '0) begin
                res_status_nxt = stia_pkg::STAT_NOT_FOUND;
                state_nxt      = ST_DONE;
              end
            end
            stia_pkg::REQ_QUERY: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // read of slot n is issued while slot n-1 is checked
        rd_vld_nxt = !issue_end_r;
        rd_idx_nxt = scan_addr_r;
        if (!issue_end_r) begin
          if (scan_addr_r == LAST_IDX) begin
            issue_end_nxt = 1'b1;
          end else begin
            scan_addr_nxt = scan_addr_r + IDX_W'(1);
          end
        end
        if (rd_vld_r) begin
          if (slot_hit) begin
            res_idx_nxt = rd_idx_r;
            state_nxt   = ST_DONE;
            if (req_r == stia_pkg::REQ_INSERT) begin
              wr_en       = 1'b1;
              wr_data     = {1'b1, id_ctr_r};
              res_id_nxt  = id_ctr_r;
              id_ctr_nxt  = id_ctr_r + ID_BITS'(1);
              occ_cnt_nxt = occ_cnt_r + CNT_W'(1);
            end else if (req_r == stia_pkg::REQ_DELETE) begin
              wr_en       = 1'b1;
              wr_data     = {1'b0, rd_data[ID_BITS-1:0]};
              occ_cnt_nxt = occ_cnt_r - CNT_W'(1);
            end
          end else if (rd_idx_r == LAST_IDX) begin
            res_status_nxt = stia_pkg::STAT_NOT_FOUND;
            state_nxt      = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_idx_nxt    = stia_pkg::SLOT_W'(res_idx_r);
          out_id_nxt     = stia_pkg::NEWID_W'(res_id_r);
          out_occ_nxt    = (occ_cnt_r != '0);
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      scan_addr_r <= '0;
      issue_end_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      occ_cnt_r   <= '0;
      id_ctr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_addr_r <= scan_addr_nxt;
      issue_end_r <= issue_end_nxt;
      rd_vld_r    <= rd_vld_nxt;
      occ_cnt_r   <= occ_cnt_nxt;
      id_ctr_r    <= id_ctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_idx_r     <= rd_idx_nxt;
    req_r        <= req_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_id_r     <= res_id_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_id_r     <= out_id_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot_index   = out_idx_r;
  assign out_new_id       = out_id_r;
  assign out_any_occupied = out_occ_r;

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_cnt_r <= FULL_CNT)
    else $error("occupancy count above slot count");

  a_id_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (id_ctr_r != $past(id_ctr_r)) |-> (occ_cnt_r == $past(occ_cnt_r) + CNT_W'(1)))
    else $error("id counter advanced without a slot being filled");

  a_occ_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_cnt_r != $past(occ_cnt_r)) |-> ($past(state_r) == ST_SCAN))
    else $error("occupancy changed outside a slot scan");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result transfer raised outside done state");
`endif

endmodule

@@ src/stia_slot_ram.sv @@
module stia_slot_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 17
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ test/slot_table_id_allocator_checker.sv @@
`timescale 1ns / 100ps

module slot_table_id_allocator_checker #(
  parameter int SLOT_COUNT = 16,
  parameter int ID_BITS    = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [stia_pkg::REQ_W-1:0]   in_req_type,
  input  logic [stia_pkg::KEY_W-1:0]   in_key_id,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [stia_pkg::STAT_W-1:0]  out_status,
  input  logic [stia_pkg::SLOT_W-1:0]  out_slot_index,
  input  logic [stia_pkg::NEWID_W-1:0] out_new_id,
  input  logic                         out_any_occupied,
  output int                           mismatches,
  output int                           replies_due,
  output int                           replies_seen,
  output int                           full_seen,
  output int                           miss_seen,
  output logic [stia_pkg::KEY_W-1:0]   next_ident_hint
);

  typedef struct packed {
    logic [stia_pkg::STAT_W-1:0]  status;
    logic [stia_pkg::SLOT_W-1:0]  slot;
    logic [stia_pkg::NEWID_W-1:0] ident;
    logic                         occupied;
  } table_reply_t;

  logic               slot_used [SLOT_COUNT];
  logic [ID_BITS-1:0] slot_tag  [SLOT_COUNT];
  logic [ID_BITS-1:0] next_ident;
  table_reply_t       reply_q [$];
  int                 fail_cnt;
  int                 seen_cnt;
  int                 full_cnt;
  int                 miss_cnt;

  // Applies one request to the shadow table and returns the reply it should produce.
  function automatic table_reply_t table_apply(input logic [stia_pkg::REQ_W-1:0] req,
                                               input logic [stia_pkg::KEY_W-1:0] key);
    table_reply_t       r;
    logic [ID_BITS-1:0] k;
    int                 hit;
    int                 i;
    r          = '0;
    r.status   = stia_pkg::STAT_OK;
    k          = ID_BITS'(key);
    hit        = SLOT_COUNT;
    case (req) inside
      stia_pkg::REQ_INSERT: begin
        for (i = SLOT_COUNT - 1; i >= 0; i--)
          if (!slot_used[i]) hit = i;
        if (hit < SLOT_COUNT) begin
          slot_used[hit] = 1'b1;
          slot_tag[hit]  = next_ident;
          r.slot         = hit[stia_pkg::SLOT_W-1:0];
          r.ident        = stia_pkg::NEWID_W'(next_ident);
          next_ident     = next_ident + ID_BITS'(1);
        end else begin
          r.status = stia_pkg::STAT_FULL;
        end
      end
      stia_pkg::REQ_FIND, stia_pkg::REQ_DELETE: begin
        // lowest matching slot wins when ids repeat after the wrap
        for (i = SLOT_COUNT - 1; i >= 0; i--)
          if (slot_used[i] && slot_tag[i] == k) hit = i;
        if (hit < SLOT_COUNT) begin
          r.slot = hit[stia_pkg::SLOT_W-1:0];
          if (req == stia_pkg::REQ_DELETE) slot_used[hit] = 1'b0;
        end else begin
          r.status = stia_pkg::STAT_NOT_FOUND;
        end
      end
      default: ;
    endcase
    for (i = 0; i < SLOT_COUNT; i++)
      if (slot_used[i]) r.occupied = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin : table_track
    table_reply_t want;
    table_reply_t got;
    int           i;
    if (!rst_n) begin
      for (i = 0; i < SLOT_COUNT; i++) begin
        slot_used[i] = 1'b0;
        slot_tag[i]  = '0;
      end
      next_ident = '0;
      reply_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_status, out_slot_index, out_new_id, out_any_occupied};
        seen_cnt++;
        if (reply_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: reply transfer with nothing outstanding: status %0d slot %0d id %0d",
                     $time, got.status, got.slot, got.ident);
        end else begin
          want = reply_q.pop_front();
          if (got.status !== want.status || got.slot !== want.slot ||
              got.ident !== want.ident || got.occupied !== want.occupied) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%0t: exp status %0d slot %0d id %0d occ %0b, got %0d %0d %0d %0b",
                       $time, want.status, want.slot, want.ident, want.occupied,
                       got.status, got.slot, got.ident, got.occupied);
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = table_apply(in_req_type, in_key_id);
        if (want.status == stia_pkg::STAT_FULL) full_cnt++;
        if (want.status == stia_pkg::STAT_NOT_FOUND) miss_cnt++;
        reply_q.push_back(want);
      end
    end
    mismatches      <= fail_cnt;
    replies_due     <= reply_q.size();
    replies_seen    <= seen_cnt;
    full_seen       <= full_cnt;
    miss_seen       <= miss_cnt;
    next_ident_hint <= stia_pkg::KEY_W'(next_ident);
  end

endmodule

@@ test/tb_slot_table_id_allocator_core.sv @@
`timescale 1ns / 100ps

module tb_slot_table_id_allocator_core;

  localparam int SLOT_COUNT = 16;
  localparam int ID_BITS    = 16;
  localparam int HOLD_LEN   = 300;
  localparam int RAND_ITEMS = 750;

  logic                         clk         = 1'b0;
  logic                         rst_n       = 1'b0;
  logic                         in_valid    = 1'b0;
  logic                         in_stall;
  logic [stia_pkg::REQ_W-1:0]   in_req_type = stia_pkg::REQ_QUERY;
  logic [stia_pkg::KEY_W-1:0]   in_key_id   = '0;
  logic                         out_valid;
  logic                         out_stall   = 1'b0;
  logic [stia_pkg::STAT_W-1:0]  out_status;
  logic [stia_pkg::SLOT_W-1:0]  out_slot_index;
  logic [stia_pkg::NEWID_W-1:0] out_new_id;
  logic                         out_any_occupied;

  logic               quiet       = 1'b0;  // no random idling on either side
  logic               hold_req    = 1'b0;
  logic               hold_done   = 1'b0;
  int                 hold_cnt    = 0;
  int                 sent        = 0;

  int                           mismatches;
  int                           replies_due;
  int                           replies_seen;
  int                           full_seen;
  int                           miss_seen;
  logic [stia_pkg::KEY_W-1:0]   ident_hint;

  always #10 clk = ~clk;

  slot_table_id_allocator_core #(
    .SLOT_COUNT(SLOT_COUNT),
    .ID_BITS   (ID_BITS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_key_id       (in_key_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_slot_index  (out_slot_index),
    .out_new_id      (out_new_id),
    .out_any_occupied(out_any_occupied)
  );

  slot_table_id_allocator_checker #(
    .SLOT_COUNT(SLOT_COUNT),
    .ID_BITS   (ID_BITS)
  ) u_table_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_key_id       (in_key_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_slot_index  (out_slot_index),
    .out_new_id      (out_new_id),
    .out_any_occupied(out_any_occupied),
    .mismatches      (mismatches),
    .replies_due     (replies_due),
    .replies_seen    (replies_seen),
    .full_seen       (full_seen),
    .miss_seen       (miss_seen),
    .next_ident_hint (ident_hint)
  );

  // Reply side: random stalls, plus one long hold-off so the block backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt  <= 0;
    end else if (hold_cnt != 0) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_cnt  <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 15);
    end
  end

  // One request transfer; returns at the edge where it was taken.
  task automatic send_request(input logic [stia_pkg::REQ_W-1:0] req,
                              input logic [stia_pkg::KEY_W-1:0] key);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(99) < 15) gap = $urandom_range(8, 1);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_key_id   <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic wait_replies_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_due != 0) @(posedge clk);
  endtask

  initial begin
    logic [stia_pkg::KEY_W-1:0] key;
    logic [stia_pkg::REQ_W-1:0] req;
    int                         pick;
    int                         ins_pct;
    int                         i;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, then fill to full and poke at it
    send_request(stia_pkg::REQ_QUERY, '0);
    send_request(stia_pkg::REQ_FIND, '0);
    send_request(stia_pkg::REQ_DELETE, '1);
    for (i = 0; i < SLOT_COUNT; i++)
      send_request(stia_pkg::REQ_INSERT, stia_pkg::KEY_W'(i * 4099));
    send_request(stia_pkg::REQ_INSERT, '1);
    send_request(stia_pkg::REQ_FIND, stia_pkg::KEY_W'(SLOT_COUNT - 1));
    send_request(stia_pkg::REQ_FIND, '1);
    send_request(stia_pkg::REQ_DELETE, '0);
    send_request(stia_pkg::REQ_QUERY, '1);

    // slot 0 refills with a fresh id; id 1 is found, freed, then missed
    send_request(stia_pkg::REQ_INSERT, '0);
    send_request(stia_pkg::REQ_FIND, 16'd1);
    send_request(stia_pkg::REQ_DELETE, 16'd1);
    send_request(stia_pkg::REQ_FIND, 16'd1);
    send_request(stia_pkg::REQ_DELETE, 16'd1);
    send_request(stia_pkg::REQ_FIND, 16'd1);

    // random mix: first half leans to inserts, second half to deletes
    for (i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS / 3) hold_req <= 1'b1;
      if (i == 2 * RAND_ITEMS / 3) wait_replies_done();
      if (i == 3 * RAND_ITEMS / 4) quiet <= 1'b1;
      if (i == 9 * RAND_ITEMS / 10) quiet <= 1'b0;
      ins_pct = (i < RAND_ITEMS / 2) ? 45 : 20;
      pick    = $urandom_range(99);
      if (pick < ins_pct) req = stia_pkg::REQ_INSERT;
      else if (pick < ins_pct + 20) req = stia_pkg::REQ_FIND;
      else if (pick < 90) req = stia_pkg::REQ_DELETE;
      else req = stia_pkg::REQ_QUERY;
      // mostly aim at recently issued ids so lookups tend to hit
      if ($urandom_range(99) < 70)
        key = stia_pkg::KEY_W'(ident_hint - $urandom_range(24, 1));
      else
        key = stia_pkg::KEY_W'($urandom);
      send_request(req, key);
    end

    wait_replies_done();
    repeat (SLOT_COUNT + 8) @(posedge clk);
    $display("%0d requests, %0d replies checked over fill, drain and a long reply hold-off",
             sent, replies_seen);
    $display("%0d inserts found the table full, %0d finds/deletes missed",
             full_seen, miss_seen);
    if (mismatches == 0 && replies_due == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("timeout: slot table stopped making progress");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ sim.f @@
src/stia_pkg.sv
src/stia_slot_ram.sv
src/slot_table_id_allocator_core.sv
test/slot_table_id_allocator_checker.sv
test/tb_slot_table_id_allocator_core.sv
